// ----- design/arlm_pkg.sv -----
// ----------------------------------------------------------------------------
// arlm_pkg
// Shared types and constants of the audio rms level meter: item and result
// beats, the report job handed from the front to the back, and the fixed-point
// constants of the log2 and dB conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package arlm_pkg;

  // decimation and count sizing
  localparam int unsigned DECIMATION  = 64;
  localparam int unsigned PHASE_W     = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned SQ_W        = 31;                 // square of a 16-bit sample
  localparam int unsigned SUM_W       = COUNT_WIDTH + 30;   // Q30 sum of squares
  localparam int unsigned ELAPSED_W   = 16;

  // beat field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 17;

  // configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OFFSET = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     INTERVAL_RESET   = CFG_W'(1000);

  // item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // job queue between front and back
  localparam int unsigned JQ_DEPTH = 2;
  localparam int unsigned JQ_AW    = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;

  // silence test: sum*5^10 <= count*2^20, only for sums below 2^36
  localparam int unsigned SIL_SUM_W  = 36;
  localparam int unsigned SIL_W      = 60;
  localparam int unsigned SIL_ITERS  = 10;
  localparam int unsigned SIL_SHIFT  = 20;

  // log2 unit
  localparam int unsigned NORM_W    = SUM_W;
  localparam int unsigned MM_W      = 31;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned EXP_W     = $clog2(NORM_W);
  localparam int unsigned LOG_W     = EXP_W + FRAC_W;
  localparam int unsigned LOG_ITERS = FRAC_W;
  localparam int unsigned IT_W      = $clog2(LOG_ITERS);
  localparam logic [LOG_W-1:0] Q30_LOG_BIAS = LOG_W'(30) << FRAC_W;

  // dB conversion: 2560*log10(2) in Q20, rounded Q44 product
  localparam int unsigned DBK_W        = 30;
  localparam logic [DBK_W-1:0] DB_PER_LOG2_Q20 = DBK_W'(808071242);
  localparam int unsigned PROD_W       = LOG_W + DBK_W;
  localparam int unsigned ROUND_SHIFT  = 44;
  localparam int unsigned DB_W         = PROD_W + 1 - ROUND_SHIFT;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       buffer_start;
  } item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_db;
    logic [COUNT_WIDTH-1:0]    sample_count;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0]        square_sum;
    logic [COUNT_WIDTH-1:0]  kept_count;
    logic signed [CFG_W-1:0] level_offset;
  } job_t;

endpackage

`default_nettype wire

// ----- design/arlm_front.sv -----
// ----------------------------------------------------------------------------
// arlm_front
// Accepts sample and tick beats, decimates and accumulates squares, counts
// milliseconds and hands a report job to the back when the interval is reached.
// ----------------------------------------------------------------------------
`default_nettype none

module arlm_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  output logic                                  full_o,
  input  wire arlm_pkg::item_t                  item_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [arlm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [arlm_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                                  job_push_o,
  output arlm_pkg::job_t                        job_o,
  input  wire logic                             job_full_i
);
  import arlm_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [PHASE_W-1:0]     PHASE_LAST = PHASE_W'(DECIMATION - 1);

  logic [CFG_W-1:0]        interval_q;
  logic signed [CFG_W-1:0] offset_q;
  logic [SUM_W-1:0]        sum_q, sum_d, sum_plus;
  logic [COUNT_WIDTH-1:0]  count_q, count_d;
  logic [PHASE_W-1:0]      phase_q, phase_d, phase_cur;
  logic [ELAPSED_W-1:0]    elapsed_q, elapsed_d, elapsed_inc;
  logic                    pend_v_q, pend_v_d;
  logic [SQ_W-1:0]         sq_q;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic accept, is_sample, is_tick, keep, hit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
      offset_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INTERVAL_MS:  interval_q <= cfg_data_i;
        REG_LEVEL_OFFSET: offset_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // beat classification
  assign full_o    = job_full_i;
  assign accept    = push_i && !job_full_i;
  assign is_sample = accept && (item_i.command == CMD_SAMPLE);
  assign is_tick   = accept && (item_i.command == CMD_TICK);

  // decimation and keep decision
  assign phase_cur = item_i.buffer_start ? '0 : phase_q;
  assign keep      = is_sample && (phase_cur == '0) && (count_q != COUNT_MAX);
  assign sq_full   = $signed(item_i.sample) * $signed(item_i.sample);

  // square is added to the sum in the cycle after its sample
  assign sum_plus = sum_q + (pend_v_q ? SUM_W'(sq_q) : '0);

  // millisecond counting
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
  assign hit         = is_tick && (elapsed_inc >= interval_q);

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    elapsed_d = elapsed_q;
    sum_d     = sum_plus;
    pend_v_d  = keep;
    if (is_sample) begin
      phase_d = (phase_cur == PHASE_LAST) ? '0 : phase_cur + 1'b1;
      if (keep) begin
        count_d = count_q + 1'b1;
      end
    end
    if (is_tick) begin
      elapsed_d = elapsed_inc;
      if (hit) begin
        sum_d     = '0;
        count_d   = '0;
        elapsed_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      count_q   <= '0;
      phase_q   <= '0;
      elapsed_q <= '0;
      pend_v_q  <= 1'b0;
    end else begin
      sum_q     <= sum_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      pend_v_q  <= pend_v_d;
    end
  end

  // square staging register
  always_ff @(posedge clk_i) begin
    sq_q <= sq_full[SQ_W-1:0];
  end

  // report job, only when something was kept
  assign job_push_o         = hit && (count_q != '0);
  assign job_o.square_sum   = sum_plus;
  assign job_o.kept_count   = count_q;
  assign job_o.level_offset = offset_q;

endmodule

`default_nettype wire

// ----- design/arlm_job_queue.sv -----
// ----------------------------------------------------------------------------
// arlm_job_queue
// Short first-in first-out queue of report jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module arlm_job_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire arlm_pkg::job_t data_i,
  output logic                full_o,
  output logic                valid_o,
  output arlm_pkg::job_t      data_o,
  input  wire logic           pop_i
);
  import arlm_pkg::*;

  localparam logic [JQ_AW-1:0] PTR_LAST = JQ_AW'(JQ_DEPTH - 1);
  localparam logic [JQ_AW:0]   CNT_FULL = (JQ_AW + 1)'(JQ_DEPTH);

  job_t             mem_q [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_q, rd_q;
  logic [JQ_AW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/arlm_back.sv -----
// ----------------------------------------------------------------------------
// arlm_back
// Sequencer that turns one report job into a level: silence test by repeated
// times-five, log2 of count and sum by normalize and repeated squaring, dB
// scaling with rounding, offset and saturation, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arlm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire arlm_pkg::job_t job_i,
  output logic                job_pop_o,
  output logic                empty_o,
  output arlm_pkg::result_t   result_o,
  input  wire logic           pop_i
);
  import arlm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SIL  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_LOG  = 4'd4;
  localparam logic [3:0] S_LEND = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_RND  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam int unsigned LVL_W = LEVEL_W + 2;
  localparam logic signed [LVL_W-1:0] LEVEL_MIN = -(LVL_W'(1) <<< (LEVEL_W - 1));
  localparam logic signed [LVL_W-1:0] LEVEL_MAX = (LVL_W'(1) <<< (LEVEL_W - 1)) - 1;
  localparam logic [EXP_W-1:0] EXP_TOP  = EXP_W'(NORM_W - 1);
  localparam logic [IT_W-1:0]  SIL_LAST = IT_W'(SIL_ITERS - 1);
  localparam logic [IT_W-1:0]  LOG_LAST = IT_W'(LOG_ITERS - 1);
  localparam logic [PROD_W:0]  ROUND_HALF = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);

  logic [3:0]              state_q;
  logic [IT_W-1:0]         it_q;
  logic                    sel_q, big_q, zero_q, out_v_q;
  logic [SUM_W-1:0]        sum_q;
  logic [COUNT_WIDTH-1:0]  cnt_q;
  logic signed [CFG_W-1:0] ofs_q;
  logic [SIL_W-1:0]        t_q;
  logic [NORM_W-1:0]       m_q;
  logic [EXP_W-1:0]        e_q;
  logic [MM_W-1:0]         mm_q;
  logic [FRAC_W-1:0]       frac_q;
  logic [LOG_W-1:0]        top_q, mag_q, logv;
  logic [PROD_W-1:0]       prod_q;
  logic [DB_W-1:0]         db_q;
  result_t                 res_q;

  logic [2*MM_W-1:0]       mm_sq;
  logic [MM_W:0]           mm_next;
  logic [SIL_W-1:0]        cnt_shift;
  logic [PROD_W:0]         rnd;
  logic signed [LVL_W-1:0] lvl_wide, lvl_sat;
  logic                    out_free, silent;

  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign out_free  = !out_v_q || pop_i;
  assign empty_o   = !out_v_q;
  assign result_o  = res_q;

  // one squaring step of the log2 unit
  assign mm_sq   = mm_q * mm_q;
  assign mm_next = mm_sq[2*MM_W-1 -: MM_W+1];
  assign logv    = {e_q, frac_q};

  // silence compare and final rounding
  assign cnt_shift = SIL_W'(cnt_q) << SIL_SHIFT;
  assign silent    = !big_q && (t_q <= cnt_shift);
  assign rnd       = {1'b0, prod_q} + ROUND_HALF;

  // offset and saturation
  assign lvl_wide = LVL_W'(ofs_q) - $signed({2'b00, db_q});
  always_comb begin
    if (lvl_wide < LEVEL_MIN) begin
      lvl_sat = LEVEL_MIN;
    end else if (lvl_wide > LEVEL_MAX) begin
      lvl_sat = LEVEL_MAX;
    end else begin
      lvl_sat = lvl_wide;
    end
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      it_q    <= '0;
      sel_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            state_q <= S_SIL;
            it_q    <= '0;
          end
        end
        S_SIL: begin
          it_q <= it_q + 1'b1;
          if (it_q == SIL_LAST) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          sel_q   <= 1'b0;
          state_q <= silent ? S_DONE : S_NORM;
        end
        S_NORM: begin
          if (m_q[NORM_W-1] || (e_q == '0)) begin
            state_q <= S_LOG;
            it_q    <= '0;
          end
        end
        S_LOG: begin
          it_q <= it_q + 1'b1;
          if (it_q == LOG_LAST) begin
            state_q <= S_LEND;
          end
        end
        S_LEND: begin
          sel_q   <= 1'b1;
          state_q <= sel_q ? S_MUL : S_NORM;
        end
        S_MUL:  state_q <= S_RND;
        S_RND:  state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // output register valid
      if ((state_q == S_DONE) && out_free) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        sum_q  <= job_i.square_sum;
        cnt_q  <= job_i.kept_count;
        ofs_q  <= job_i.level_offset;
        t_q    <= SIL_W'(job_i.square_sum);
        big_q  <= (job_i.square_sum >> SIL_SUM_W) != '0;
        zero_q <= 1'b0;
      end
      S_SIL: begin
        t_q <= t_q + (t_q << 2);
      end
      S_CHK: begin
        zero_q <= silent;
        m_q    <= NORM_W'(cnt_q);
        e_q    <= EXP_TOP;
      end
      S_NORM: begin
        if (m_q[NORM_W-1] || (e_q == '0)) begin
          mm_q   <= m_q[NORM_W-1 -: MM_W];
          frac_q <= '0;
        end else begin
          m_q <= m_q << 1;
          e_q <= e_q - 1'b1;
        end
      end
      S_LOG: begin
        if (mm_next[MM_W]) begin
          mm_q   <= mm_next[MM_W:1];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          mm_q   <= mm_next[MM_W-1:0];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
        end
      end
      S_LEND: begin
        if (!sel_q) begin
          top_q <= logv + Q30_LOG_BIAS;
          m_q   <= sum_q;
          e_q   <= EXP_TOP;
        end else begin
          mag_q <= (top_q > logv) ? top_q - logv : '0;
        end
      end
      S_MUL: begin
        prod_q <= mag_q * DB_PER_LOG2_Q20;
      end
      S_RND: begin
        db_q <= rnd[PROD_W -: DB_W];
      end
      S_DONE: begin
        if (out_free) begin
          res_q.level_db     <= zero_q ? '0 : lvl_sat[LEVEL_W-1:0];
          res_q.sample_count <= cnt_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/audio_rms_level_meter.sv -----
// Samples and millisecond ticks are taken one per cycle while full_o is low;
// full_o rises only while two finished reports wait in the job queue for the
// level unit. Once the level unit takes a job, it runs ten times-five steps
// for the silence test, then for count and for sum a one-bit-per-cycle
// normalize and 24 squaring steps of one 31x31 multiplier, then one multiply
// and a round step. Reports queued behind earlier ones wait their turn. The
// result waits in an output register until popped.
// ----------------------------------------------------------------------------
// audio_rms_level_meter
// Decimated mean-square level meter reporting 10*log10 of the mean square in
// 1/256 dB with a programmable interval and calibration offset.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_rms_level_meter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire arlm_pkg::item_t                item_i,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output arlm_pkg::result_t                   result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [arlm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [arlm_pkg::CFG_W-1:0]     cfg_data_i
);
  import arlm_pkg::*;

  logic job_push, job_full, job_valid, job_pop;
  job_t job_in, job_out;

  // front: accumulate and time
  arlm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  // report jobs in flight
  arlm_job_queue u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .valid_o (job_valid),
    .data_o  (job_out),
    .pop_i   (job_pop)
  );

  // back: level computation
  arlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty_o),
    .result_o    (result_o),
    .pop_i       (pop_i)
  );

endmodule

`default_nettype wire

// ----- design/arlm_checker.sv -----
// ----------------------------------------------------------------------------
// arlm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arlm_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic                           full_o,
  input  wire arlm_pkg::item_t                item_i,
  input  wire logic                           empty_o,
  input  wire logic                           pop_i,
  input  wire arlm_pkg::result_t              result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [arlm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [arlm_pkg::CFG_W-1:0]     cfg_data_i
);
  import arlm_pkg::*;

  // reset leaves both queues clear
  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |=> (empty_o && !full_o))
    else $error("queues not clear after reset");

  // a waiting result beat holds until popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(result_o)))
    else $error("result beat changed while waiting");

  // an empty interval never reports
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (result_o.sample_count != '0))
    else $error("report with zero kept samples");

endmodule

bind audio_rms_level_meter arlm_checker u_checker (.*);

`default_nettype wire
